// ===== rtl/mlsw_pkg.sv =====
// shared types and constants for the misaligned load/store word memory
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mlsw_pkg;

   localparam int ADDR_W      = 12;                       // byte address width
   localparam int DATA_W      = 32;                       // memory word width
   localparam int CODE_W      = 3;                        // funct3 width
   localparam int LANE_W      = 2;                        // byte lane offset width
   localparam int WIDX_W      = ADDR_W - LANE_W;          // word index from the address
   localparam int INDEX_SPAN  = 1 << WIDX_W;              // words the address can name
   localparam int IDXF_W      = WIDX_W + 1;               // index incl. spill past the span
   localparam int REQ_TDATA_W = ((CODE_W + ADDR_W + DATA_W + 7) / 8) * 8;
   localparam int QUEUE_DEPTH = 2;

   // access direction
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // access size, funct3[1:0]
   localparam logic [1:0] SIZE_BYTE   = 2'b00;
   localparam logic [1:0] SIZE_HALF   = 2'b01;
   localparam logic [1:0] SIZE_WORD   = 2'b10;
   localparam logic [1:0] SIZE_DOUBLE = 2'b11;

   // what the back end does with an entry
   localparam logic [1:0] KIND_NONE  = 2'b00;             // no memory effect, result 0
   localparam logic [1:0] KIND_LOAD  = 2'b01;
   localparam logic [1:0] KIND_STORE = 2'b10;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        size;
      logic [LANE_W-1:0] lane;
      logic [IDXF_W-1:0] idx;
      logic [IDXF_W-1:0] nidx;
      logic [DATA_W-1:0] data;
   } mem_access_type;

endpackage

`default_nettype wire

// ===== rtl/mlsw_front.sv =====
// front end: takes requests, decodes funct3 and reduces the word index
// depends on mlsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module mlsw_front #(
   parameter int USED_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        opcode,
   input  logic [mlsw_pkg::CODE_W-1:0] width_code,
   input  logic [mlsw_pkg::ADDR_W-1:0] byte_address,
   input  logic [mlsw_pkg::DATA_W-1:0] store_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output mlsw_pkg::mem_access_type    out_entry
);
   import mlsw_pkg::*;

   localparam int SPLIT = WIDX_W / 2;

   logic              fr_valid_ff, fr_valid_in;
   logic [1:0]        fr_kind_ff, fr_kind_in;
   logic [1:0]        fr_size_ff;
   logic [LANE_W-1:0] fr_lane_ff;
   logic [WIDX_W-1:0] fr_idx_ff, fr_idx_in;
   logic [DATA_W-1:0] fr_data_ff;
   logic              in_fire;
   logic [WIDX_W-1:0] fin_idx;
   logic [IDXF_W-1:0] nxt_idx;

   assign in_ready = enable && (!fr_valid_ff || out_ready);
   assign in_fire  = in_valid && in_ready;

   // decode
   always_comb begin
      fr_kind_in = KIND_NONE;
      if (opcode == OP_LOAD) begin
         if (width_code[1:0] != SIZE_DOUBLE) fr_kind_in = KIND_LOAD;
      end else begin
         if (!width_code[2] && width_code[1:0] != SIZE_DOUBLE) fr_kind_in = KIND_STORE;
      end
   end

   // upper half of the restoring modulo reduction
   always_comb begin
      fr_idx_in = byte_address[ADDR_W-1:LANE_W];
      for (int k = WIDX_W - 1; k >= SPLIT; k--) begin
         if (32'(fr_idx_in) >= 32'(USED_DEPTH << k))
            fr_idx_in = fr_idx_in - WIDX_W'(USED_DEPTH << k);
      end
   end

   // lower half, then the wrapped next index
   always_comb begin
      fin_idx = fr_idx_ff;
      for (int k = SPLIT - 1; k >= 0; k--) begin
         if (32'(fin_idx) >= 32'(USED_DEPTH << k))
            fin_idx = fin_idx - WIDX_W'(USED_DEPTH << k);
      end
      nxt_idx = {1'b0, fin_idx} + IDXF_W'(1);
      if (32'(nxt_idx) == 32'(USED_DEPTH)) nxt_idx = '0;
   end

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (in_fire) fr_valid_in = 1'b1;
      else if (out_ready) fr_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         fr_kind_ff <= fr_kind_in;
         fr_size_ff <= width_code[1:0];
         fr_lane_ff <= byte_address[LANE_W-1:0];
         fr_idx_ff  <= fr_idx_in;
         fr_data_ff <= store_data;
      end
   end

   assign out_valid       = fr_valid_ff;
   assign out_entry.kind  = fr_kind_ff;
   assign out_entry.size  = fr_size_ff;
   assign out_entry.lane  = fr_lane_ff;
   assign out_entry.idx   = {1'b0, fin_idx};
   assign out_entry.nidx  = nxt_idx;
   assign out_entry.data  = fr_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mlsw_queue.sv =====
// short queue of decoded accesses between front and back end
// depends on mlsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module mlsw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mlsw_pkg::mem_access_type in_entry,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mlsw_pkg::mem_access_type out_entry
);
   import mlsw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   mem_access_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_entry;
   end

   // fill level follows pushes and pops one for one
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== rtl/mlsw_back.sv =====
// back end: word memory, clearing pass, load alignment and store merge
// depends on mlsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module mlsw_back #(
   parameter int USED_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        clear_done,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  mlsw_pkg::mem_access_type    in_entry,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mlsw_pkg::DATA_W-1:0] rsp_tdata
);
   import mlsw_pkg::*;

   localparam int IDX_W = $clog2(USED_DEPTH);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_WRITE2 = 2'd3;

   logic [DATA_W-1:0]   word_mem_ff [USED_DEPTH];
   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   mem_access_type      cur_ff;
   logic [DATA_W-1:0]   rd_a_ff, rd_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                pop;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [DATA_W-1:0]   wr_data;
   logic [4:0]          lane_sh;
   logic [DATA_W-1:0]   mask32;
   logic [2*DATA_W-1:0] mask64, ins64, pair64, rot64;
   logic                spill;
   logic [DATA_W-1:0]   load_word;

   assign clear_done = (state_ff != ST_CLEAR);
   assign in_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign pop        = in_valid && in_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // lane alignment and merge
   always_comb begin
      lane_sh = {cur_ff.lane, 3'b000};
      unique case (cur_ff.size)
         SIZE_BYTE: mask32 = 32'h0000_00FF;
         SIZE_HALF: mask32 = 32'h0000_FFFF;
         SIZE_WORD: mask32 = 32'hFFFF_FFFF;
         default:   mask32 = '0;
      endcase
      mask64    = {{DATA_W{1'b0}}, mask32} << lane_sh;
      ins64     = ({{DATA_W{1'b0}}, cur_ff.data} << lane_sh) & mask64;
      pair64    = ({rd_b_ff, rd_a_ff} & ~mask64) | ins64;
      spill     = |mask64[2*DATA_W-1:DATA_W];
      rot64     = {rd_a_ff, rd_a_ff} >> lane_sh;
      load_word = rot64[DATA_W-1:0] & mask32;
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      wr_en        = 1'b0;
      wr_idx       = cur_ff.idx[IDX_W-1:0];
      wr_data      = pair64[DATA_W-1:0];
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_idx_ff;
            wr_data = '0;
            if (clr_idx_ff == IDX_W'(USED_DEPTH - 1)) state_in = ST_IDLE;
            else clr_idx_in = clr_idx_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            if (pop) state_in = ST_READ;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = (cur_ff.kind == KIND_LOAD) ? load_word : '0;
            state_in     = ST_IDLE;
            if (cur_ff.kind == KIND_STORE) begin
               wr_en = 1'b1;
               if (spill) state_in = ST_WRITE2;
            end
         end
         ST_WRITE2: begin
            wr_en    = 1'b1;
            wr_idx   = cur_ff.nidx[IDX_W-1:0];
            wr_data  = pair64[2*DATA_W-1:DATA_W];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (pop) cur_ff <= in_entry;
   end

   // word memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) word_mem_ff[wr_idx] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_a_ff <= word_mem_ff[in_entry.idx[IDX_W-1:0]];
         rd_b_ff <= word_mem_ff[in_entry.nidx[IDX_W-1:0]];
      end
   end

   // the result slot is always free when a read completes
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result slot busy at read completion");

   // the second write only follows a spilling store
   a_spill_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE2) |-> ($past(state_ff) == ST_READ && cur_ff.kind == KIND_STORE))
      else $error("second word write without a store");

   // a result appears only right after a read
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_READ)
      else $error("result raised outside read completion");

endmodule

`default_nettype wire

// ===== rtl/misaligned_load_store_word_memory_unit.sv =====
// top level of the misaligned load/store word memory
// depends on mlsw_pkg, mlsw_front, mlsw_queue, mlsw_back
`timescale 1ns / 1ps
`default_nettype none

// Word-organized data memory for RISC-V style byte-addressed loads and stores.
// Each request carries opcode (load or store), funct3 width code, a 12-bit
// byte address and store data; each request yields exactly one response.
// Loads rotate the addressed word right by the lane offset and keep 8, 16 or
// 32 bits zero-extended (signed codes behave like unsigned ones, funct3 3 and
// 7 return 0). Stores merge a byte, half or word into the addressed lanes; a
// misaligned half or word store continues into the next word, whose index
// wraps modulo WORD_DEPTH. Doubleword and unknown store codes change nothing,
// and every store responds with 0. After reset the block runs a clearing
// pass over min(WORD_DEPTH, 1025) words that zeroes the memory, with
// req_tready low. Afterwards the sequencer reads the addressed words as it
// accepts an access, then aligns or merges in its read state; a spilling
// store adds a second write state (its second word goes through the single
// write port). It takes no new access before it is through with the last
// one, and so sets the sustained rate. When idle the response passes the
// decode register, a queue slot and the memory read registers, after which
// the result register presents it. A two-entry queue lets the front keep
// taking requests while the back end or the response side stalls.

module misaligned_load_store_word_memory_unit #(
   parameter int WORD_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mlsw_pkg::REQ_TDATA_W-1:0] req_tdata,  // width_code, byte_address, store_data
   input  logic                             req_tuser,  // opcode
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mlsw_pkg::DATA_W-1:0]      rsp_tdata   // load_data
);
   import mlsw_pkg::*;

   // the address reaches INDEX_SPAN words, a spill one more
   localparam int USED_DEPTH = (WORD_DEPTH < INDEX_SPAN + 1) ? WORD_DEPTH : INDEX_SPAN + 1;

   localparam int CODE_LSB = 0;
   localparam int ADDR_LSB = CODE_LSB + CODE_W;
   localparam int DATA_LSB = ADDR_LSB + ADDR_W;

   logic           clear_done;
   logic           fq_valid, fq_ready;
   mem_access_type fq_entry;
   logic           qb_valid, qb_ready;
   mem_access_type qb_entry;

   // decode and index reduction
   mlsw_front #(
      .USED_DEPTH (USED_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (clear_done),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .opcode       (req_tuser),
      .width_code   (req_tdata[ADDR_LSB-1:CODE_LSB]),
      .byte_address (req_tdata[DATA_LSB-1:ADDR_LSB]),
      .store_data   (req_tdata[DATA_LSB+DATA_W-1:DATA_LSB]),
      .out_valid    (fq_valid),
      .out_ready    (fq_ready),
      .out_entry    (fq_entry)
   );

   // decoupling queue
   mlsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_entry (qb_entry)
   );

   // memory and access sequencer
   mlsw_back #(
      .USED_DEPTH (USED_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_done (clear_done),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_entry   (qb_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
